// ===== rtl/core/clt_pkg.sv =====
`default_nettype none

package clt_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [15:0] SOFT_BASE = 16'h0000;
  localparam logic [15:0] CMP_BASE  = 16'h4000;
  localparam logic [15:0] TIME_ADDR = 16'hBFF8;

  localparam int unsigned IRQ_BITS = 4;

  typedef enum logic [1:0] {
    KIND_UNMAPPED = 2'd0,
    KIND_SOFT     = 2'd1,
    KIND_CMP      = 2'd2,
    KIND_TIME     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [63:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [63:0]         read_data;
    logic                access_error;
    logic [IRQ_BITS-1:0] soft_irq;
    logic [IRQ_BITS-1:0] timer_irq;
  } out_word_t;

  typedef struct packed {
    logic rd_en;
    logic cmp_we;
    logic soft_we;
  } store_req_t;

  typedef struct packed {
    logic                busy;
    logic [IRQ_BITS-1:0] soft_irq;
    logic [IRQ_BITS-1:0] timer_irq;
  } store_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/clt_decode.sv =====
`default_nettype none

module clt_decode #(
  parameter int unsigned HARTS = 4,
  localparam int unsigned HartW = (HARTS > 1) ? $clog2(HARTS) : 1
) (
  input  logic [15:0]      address_i,
  output clt_pkg::kind_e   kind_o,
  output logic [HartW-1:0] hart_o
);

  import clt_pkg::*;

  logic [15:0] cmp_off;
  logic [15:0] soft_off;
  logic [12:0] cmp_hart;
  logic [11:0] soft_hart;

  assign cmp_off   = address_i - CMP_BASE;
  assign soft_off  = address_i - SOFT_BASE;
  assign cmp_hart  = cmp_off[15:3];
  assign soft_hart = soft_off[13:2];

  always_comb begin
    kind_o = KIND_UNMAPPED;
    hart_o = '0;
    if (address_i == TIME_ADDR) begin
      kind_o = KIND_TIME;
    end else if (address_i >= CMP_BASE) begin
      if (cmp_off[2:0] == 3'd0 && cmp_hart < 13'(HARTS)) begin
        kind_o = KIND_CMP;
        hart_o = cmp_hart[HartW-1:0];
      end
    end else if (soft_off[1:0] == 2'd0 && soft_hart < 12'(HARTS)) begin
      kind_o = KIND_SOFT;
      hart_o = soft_hart[HartW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/clt_hart_store.sv =====
`default_nettype none

module clt_hart_store #(
  parameter int unsigned HARTS = 4,
  localparam int unsigned HartW = (HARTS > 1) ? $clog2(HARTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clt_pkg::store_req_t  req_i,
  input  logic [HartW-1:0]     hart_i,
  input  logic [63:0]          data_i,
  input  logic [63:0]          time_i,
  output logic [63:0]          rd_cmp_o,
  output logic                 rd_soft_o,
  output clt_pkg::store_stat_t stat_o
);

  import clt_pkg::*;

  logic [63:0] cmp_mem [HARTS];
  logic        soft_mem [HARTS];

  logic             clr_busy_q;
  logic [HartW-1:0] clr_idx_q;
  logic [63:0]      rd_cmp_q;
  logic             rd_soft_q;

  // After reset the sweep walks every hart slot once before words are taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == HartW'(HARTS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      cmp_mem[clr_idx_q]  <= '1;
      soft_mem[clr_idx_q] <= 1'b0;
    end else begin
      if (req_i.cmp_we) begin
        cmp_mem[hart_i] <= data_i;
      end
      if (req_i.soft_we) begin
        soft_mem[hart_i] <= data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_cmp_q  <= cmp_mem[hart_i];
      rd_soft_q <= soft_mem[hart_i];
    end
  end

  assign rd_cmp_o  = rd_cmp_q;
  assign rd_soft_o = rd_soft_q;

  // The first harts keep a flop copy so their interrupt lines are live every cycle.
  for (genvar h = 0; h < IRQ_BITS; h++) begin : g_irq
    if (h < HARTS) begin : g_hart
      logic [63:0] cmp_q;
      logic        soft_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cmp_q  <= '1;
          soft_q <= 1'b0;
        end else begin
          if (req_i.cmp_we && hart_i == HartW'(h)) begin
            cmp_q <= data_i;
          end
          if (req_i.soft_we && hart_i == HartW'(h)) begin
            soft_q <= data_i[0];
          end
        end
      end

      assign stat_o.soft_irq[h]  = soft_q;
      assign stat_o.timer_irq[h] = (time_i >= cmp_q);
    end else begin : g_none
      assign stat_o.soft_irq[h]  = 1'b0;
      assign stat_o.timer_irq[h] = 1'b0;
    end
  end

  assign stat_o.busy = clr_busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/core_local_timer_and_soft_irq.sv =====
`default_nettype none
// Path: an accepted word is held in the first stage, then its result word is registered at the output.
// Throughput: one word per cycle unless the output stalls or the reset sweep runs; the hart register memory
// read port is registered, which shapes the result path but does not limit the rate.
// Reset: time is cleared at once; a sweep then sets every compare register to all
// ones and clears every software bit, stalling the input until the sweep ends.

module core_local_timer_and_soft_irq #(
  parameter int unsigned HARTS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  clt_pkg::in_word_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output clt_pkg::out_word_t out_o
);

  import clt_pkg::*;

  localparam int unsigned HartW = (HARTS > 1) ? $clog2(HARTS) : 1;

  logic             accept;
  kind_e            in_kind;
  logic [HartW-1:0] in_hart;
  store_req_t       req;
  store_stat_t      stat;
  logic [63:0]      rd_cmp;
  logic             rd_soft;

  logic [63:0] time_q, time_d;
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_cmd_q;
  kind_e       s1_kind_q;
  logic        s1_adv;
  logic        out_valid_q;
  out_word_t   out_q;
  out_word_t   res;

  clt_decode #(.HARTS(HARTS)) u_decode (
    .address_i (in_i.address),
    .kind_o    (in_kind),
    .hart_o    (in_hart)
  );

  clt_hart_store #(.HARTS(HARTS)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .hart_i    (in_hart),
    .data_i    (in_i.write_data),
    .time_i    (time_q),
    .rd_cmp_o  (rd_cmp),
    .rd_soft_o (rd_soft),
    .stat_o    (stat)
  );

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stat.busy || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    req.rd_en   = accept && in_i.command == CMD_READ &&
                  (in_kind == KIND_CMP || in_kind == KIND_SOFT);
    req.cmp_we  = accept && in_i.command == CMD_WRITE && in_kind == KIND_CMP;
    req.soft_we = accept && in_i.command == CMD_WRITE && in_kind == KIND_SOFT;
  end

  always_comb begin
    time_d = time_q;
    if (accept) begin
      if (in_i.command == CMD_TICK) begin
        time_d = time_q + 64'd1;
      end else if (in_i.command == CMD_WRITE && in_kind == KIND_TIME) begin
        time_d = in_i.write_data;
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      time_q     <= time_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= in_i.command;
      s1_kind_q <= in_kind;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // State registers already hold the effect of the word in the first stage.
  always_comb begin
    res.read_data = '0;
    if (s1_cmd_q == CMD_READ) begin
      unique case (s1_kind_q)
        KIND_SOFT:     res.read_data = {63'd0, rd_soft};
        KIND_CMP:      res.read_data = rd_cmp;
        KIND_TIME:     res.read_data = time_q;
        KIND_UNMAPPED: res.read_data = '0;
        default:       res.read_data = '0;
      endcase
    end
    res.access_error = (s1_cmd_q == CMD_READ || s1_cmd_q == CMD_WRITE) &&
                       s1_kind_q == KIND_UNMAPPED;
    res.soft_irq     = stat.soft_irq;
    res.timer_irq    = stat.timer_irq;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.command == CMD_TICK) |=> time_q == $past(time_q) + 64'd1)
    else $error("time did not advance on a tick");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while the first stage is blocked");

  a_error_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.access_error) |-> out_o.read_data == 64'd0)
    else $error("unmapped access returned nonzero data");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !req.cmp_we && !req.soft_we && !req.rd_en)
    else $error("hart memory accessed during the reset sweep");

endmodule

`default_nettype wire

// ===== sim/core_local_timer_and_soft_irq_tb.sv =====
`timescale 1ns / 1ps

module core_local_timer_and_soft_irq_tb;
  import clt_pkg::*;

  localparam int unsigned HARTS = 4;
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned QUIET_WORDS = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_o;

  logic        idle_en;
  int unsigned cycle_count = 0;

  core_local_timer_and_soft_irq #(
    .HARTS(HARTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  class clint_scoreboard;
    logic [63:0] mtime;
    logic [63:0] mtimecmp [HARTS];
    logic        msip [HARTS];
    out_word_t   pending_responses [$];
    int unsigned errors;

    function new();
      mtime = '0;
      for (int h = 0; h < HARTS; h++) begin
        mtimecmp[h] = '1;
        msip[h] = 1'b0;
      end
      errors = 0;
    endfunction

    function kind_e decode_offset(input logic [15:0] addr, output int unsigned hart);
      int unsigned slot;
      hart = 0;
      if (addr == TIME_ADDR) return KIND_TIME;
      if (addr >= CMP_BASE && addr[2:0] == 3'b000) begin
        slot = (int'(addr) - int'(CMP_BASE)) >> 3;
        if (slot < HARTS) begin
          hart = slot;
          return KIND_CMP;
        end
        return KIND_UNMAPPED;
      end
      if (addr < CMP_BASE && addr[1:0] == 2'b00) begin
        slot = (int'(addr) - int'(SOFT_BASE)) >> 2;
        if (slot < HARTS) begin
          hart = slot;
          return KIND_SOFT;
        end
      end
      return KIND_UNMAPPED;
    endfunction

    function void record_request(input in_word_t w);
      out_word_t   resp;
      kind_e       kind;
      int unsigned hart;
      resp = '0;
      if (w.command == CMD_TICK) begin
        mtime = mtime + 64'd1;
      end else if (w.command == CMD_READ || w.command == CMD_WRITE) begin
        kind = decode_offset(w.address, hart);
        if (kind == KIND_UNMAPPED) begin
          resp.access_error = 1'b1;
        end else if (w.command == CMD_READ) begin
          case (kind)
            KIND_SOFT: resp.read_data = {63'd0, msip[hart]};
            KIND_CMP:  resp.read_data = mtimecmp[hart];
            default:   resp.read_data = mtime;
          endcase
        end else begin
          case (kind)
            KIND_SOFT: msip[hart] = w.write_data[0];
            KIND_CMP:  mtimecmp[hart] = w.write_data;
            default:   mtime = w.write_data;
          endcase
        end
      end
      for (int h = 0; h < IRQ_BITS && h < HARTS; h++) begin
        resp.soft_irq[h] = msip[h];
        resp.timer_irq[h] = (mtime >= mtimecmp[h]);
      end
      pending_responses.push_back(resp);
    endfunction

    function void compare_response(input out_word_t got);
      out_word_t exp;
      if (pending_responses.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp = pending_responses.pop_front();
      if (got.read_data !== exp.read_data) begin
        $error("read_data expected %h got %h", exp.read_data, got.read_data);
        errors++;
      end
      if (got.access_error !== exp.access_error) begin
        $error("access_error expected %b got %b", exp.access_error, got.access_error);
        errors++;
      end
      if (got.soft_irq !== exp.soft_irq) begin
        $error("soft_irq expected %b got %b", exp.soft_irq, got.soft_irq);
        errors++;
      end
      if (got.timer_irq !== exp.timer_irq) begin
        $error("timer_irq expected %b got %b", exp.timer_irq, got.timer_irq);
        errors++;
      end
    endfunction
  endclass

  clint_scoreboard sb;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.record_request(in_i);
    if (out_valid_o && !out_stall_i) sb.compare_response(out_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall_i = 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  function automatic in_word_t bus_word(input logic [1:0] cmd, input logic [15:0] addr,
                                        input logic [63:0] data);
    in_word_t w;
    w.command = cmd;
    w.address = addr;
    w.write_data = data;
    return w;
  endfunction

  function automatic logic [63:0] near(input logic [63:0] base);
    return base + 64'($urandom_range(0, 6)) - 64'd3;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned h;
    int unsigned target;
    w.command = CMD_READ;
    w.address = 16'($urandom_range(0, 65535));
    w.write_data = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    h = $urandom_range(0, HARTS - 1);
    if (pick < 25) begin
      w.command = CMD_TICK;
    end else if (pick < 85) begin
      w.command = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
      target = $urandom_range(0, 3);
      case (target)
        0: w.address = SOFT_BASE + 16'(4 * h);
        1: begin
          w.address = CMP_BASE + 16'(8 * h);
          case ($urandom_range(0, 3))
            0: w.write_data = near(sb.mtime);
            1: w.write_data = near(64'd0);
            2: w.write_data = '1;
            default: ;
          endcase
        end
        default: begin
          w.address = TIME_ADDR;
          case ($urandom_range(0, 3))
            0: w.write_data = near(sb.mtimecmp[h]);
            1: w.write_data = near(64'hFFFF_FFFF_FFFF_FFFF);
            2: w.write_data = near(64'd0);
            default: ;
          endcase
        end
      endcase
    end else if (pick < 95) begin
      w.command = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
    end else begin
      w.command = CMD_RESERVED;
    end
    return w;
  endfunction

  task automatic drive_word(input in_word_t w);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    drive_word(bus_word(CMD_READ, SOFT_BASE, '1));
    drive_word(bus_word(CMD_READ, CMP_BASE, '0));
    drive_word(bus_word(CMD_READ, TIME_ADDR, '0));
    drive_word(bus_word(CMD_WRITE, TIME_ADDR, 64'hFFFF_FFFF_FFFF_FFFF));
    drive_word(bus_word(CMD_TICK, TIME_ADDR, '1));
    drive_word(bus_word(CMD_READ, TIME_ADDR, '0));
    drive_word(bus_word(CMD_WRITE, CMP_BASE, 64'd0));
    drive_word(bus_word(CMD_WRITE, CMP_BASE + 16'd24, 64'd3));
    drive_word(bus_word(CMD_WRITE, SOFT_BASE + 16'd4, 64'hFFFF_FFFF_FFFF_FFFF));
    drive_word(bus_word(CMD_WRITE, SOFT_BASE + 16'd8, 64'hFFFF_FFFF_FFFF_FFFE));
    drive_word(bus_word(CMD_READ, SOFT_BASE + 16'd4, '0));
    drive_word(bus_word(CMD_WRITE, SOFT_BASE + 16'd12, 64'd1));
    drive_word(bus_word(CMD_READ, 16'h0010, '0));
    drive_word(bus_word(CMD_WRITE, 16'h4020, '1));
    drive_word(bus_word(CMD_READ, 16'h4004, '0));
    drive_word(bus_word(CMD_READ, 16'h0002, '0));
    drive_word(bus_word(CMD_WRITE, 16'hBFFC, '1));
    drive_word(bus_word(CMD_READ, 16'hFFFF, '0));
    drive_word(bus_word(CMD_READ, 16'h3FFC, '0));
    drive_word(bus_word(CMD_RESERVED, TIME_ADDR, '0));
    repeat (3) drive_word(bus_word(CMD_TICK, 16'hFFFF, '0));
    drive_word(bus_word(CMD_READ, CMP_BASE + 16'd24, '0));
    drive_word(bus_word(CMD_WRITE, CMP_BASE + 16'd8, 64'h8000_0000_0000_0000));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    idle_en = 1'b1;
    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - QUIET_WORDS) idle_en = 1'b0;
      if (i % 250 == 125) drain_responses();
      drive_word(random_word());
    end
    drain_responses();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_responses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
